// File: hdl/dcf_pkg.sv
package dcf_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int IN_W           = 16;
    localparam int CUT_W          = 34;
    localparam int CNT_W          = 7;
    localparam int START_W        = 6;
    localparam int CFG_W          = 34;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BEAD   = 1'b1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef enum logic [1:0] {
        RD_I,
        RD_K,
        RD_J
    } rd_sel_t;

    typedef struct packed {
        logic    load_pt;
        logic    run_start;
        logic    init_wr;
        rd_sel_t rd_sel;
        logic    outer_skip;
        logic    outer_open;
        logic    k_cmp;
        logic    sweep_end;
        logic    j_latch;
        logic    cluster_end;
        logic    sum_start;
        logic    sum_acc;
        logic    div_start;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic k_done;
        logic outer_done;
        logic link_self;
        logic hit;
        logic walk_more;
        logic best_empty;
        logic sum_more;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

endpackage

// File: hdl/dcf_ram.sv
module dcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/dcf_div.sv
module dcf_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 4,
    parameter int LANES = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num [LANES],
    input  logic [DEN_W-1:0]        den,
    output logic                    busy,
    output logic signed [NUM_W-1:0] quo [LANES]
);

    localparam int CNTW = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  mag_reg [LANES];
    logic [DEN_W:0]    rem_reg [LANES];
    logic              neg_reg [LANES];
    logic [DEN_W:0]    rem_sh  [LANES];
    logic [DEN_W:0]    rem_nx  [LANES];
    logic [NUM_W-1:0]  mag_nx  [LANES];
    logic              ge      [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem_sh[l] = {rem_reg[l][DEN_W-1:0], mag_reg[l][NUM_W-1]};
            ge[l]     = rem_sh[l] >= {1'b0, den_reg};
            rem_nx[l] = ge[l] ? (rem_sh[l] - {1'b0, den_reg}) : rem_sh[l];
            mag_nx[l] = {mag_reg[l][NUM_W-2:0], ge[l]};
            quo[l]    = neg_reg[l] ? $signed(~mag_reg[l] + NUM_W'(1)) : $signed(mag_reg[l]);
        end
    end

    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            for (int l = 0; l < LANES; l++)
            begin
                neg_reg[l] <= num[l] < 0;
                mag_reg[l] <= (num[l] < 0) ? NUM_W'(-num[l]) : NUM_W'(num[l]);
                rem_reg[l] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                mag_reg[l] <= mag_nx[l];
                rem_reg[l] <= rem_nx[l];
            end
        end
    end

endmodule

// File: hdl/dcf_datapath.sv
module dcf_datapath #(
    parameter int MAX_POINTS = dcf_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dcf_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dcf_pkg::dp_cmd_t                  cmd,
    output dcf_pkg::dp_stat_t                 stat,
    input  logic                              cfg_we,
    input  logic [dcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcf_pkg::CFG_W-1:0]         cfg_data,
    input  logic signed [dcf_pkg::IN_W-1:0]   pos_x,
    input  logic signed [dcf_pkg::IN_W-1:0]   pos_y,
    input  logic signed [dcf_pkg::IN_W-1:0]   pos_z,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [dcf_pkg::CNT_W-1:0]         cluster_count,
    output logic [dcf_pkg::CNT_W-1:0]         largest_size,
    output logic [dcf_pkg::START_W-1:0]       largest_start,
    output logic signed [dcf_pkg::IN_W-1:0]   centre_x,
    output logic signed [dcf_pkg::IN_W-1:0]   centre_y,
    output logic signed [dcf_pkg::IN_W-1:0]   centre_z
);

    localparam int IW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CB   = COORD_BITS;
    localparam int SW   = CB + IW + 1;
    localparam int DFW  = CB + 1;
    localparam int SQW  = 2 * DFW;
    localparam int DSW  = SQW + 2;
    localparam int CMPW = (DSW > dcf_pkg::CUT_W) ? DSW : dcf_pkg::CUT_W;
    localparam int BW   = (CW > dcf_pkg::CNT_W) ? CW : dcf_pkg::CNT_W;

    logic [dcf_pkg::CUT_W-1:0] cutoff_reg;
    logic [dcf_pkg::CNT_W-1:0] bead_reg;
    logic [CW-1:0] load_cnt_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] steps_reg;
    logic [CW-1:0] size_reg;
    logic [CW-1:0] clusters_reg;
    logic [CW-1:0] best_size_reg;
    logic [IW-1:0] j_reg;
    logic [IW-1:0] jlink_reg;
    logic [IW-1:0] best_start_reg;
    logic          out_valid_reg;

    logic signed [CB-1:0]  jc_reg   [3];
    logic signed [DFW-1:0] diff_reg [3];
    logic [SQW-1:0]        sq_reg   [3];
    logic [DSW-1:0]        dsum_reg;
    logic                  free_reg;
    logic signed [SW-1:0]  sum_reg  [3];
    logic signed [SW-1:0]  quo      [3];
    logic                  div_busy;

    logic [dcf_pkg::CNT_W-1:0]   cnt_out_reg;
    logic [dcf_pkg::CNT_W-1:0]   size_out_reg;
    logic [dcf_pkg::START_W-1:0] start_out_reg;
    logic signed [dcf_pkg::IN_W-1:0] centre_reg [3];

    logic signed [dcf_pkg::IN_W-1:0] pos [3];
    logic [CB-1:0]   coord_rd [3];
    logic [IW-1:0]   link_rd;
    logic [IW-1:0]   raddr;
    logic            store_we;
    logic            link_we;
    logic [IW-1:0]   link_waddr;
    logic [IW-1:0]   link_wdata;
    logic [BW-1:0]   bead_ext;
    logic [BW-1:0]   max_ext;
    logic [CW-1:0]   n_sat;
    logic [CW:0]     steps_inc;
    logic [CW:0]     n_wide;
    logic            hit;

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    assign bead_ext  = BW'(bead_reg);
    assign max_ext   = BW'(MAX_POINTS);
    assign n_sat     = (bead_ext > max_ext) ? CW'(max_ext) : CW'(bead_ext);
    assign steps_inc = (CW+1)'(steps_reg) + (CW+1)'(1);
    assign n_wide    = (CW+1)'(n_reg);
    assign hit       = free_reg && (CMPW'(dsum_reg) <= CMPW'(cutoff_reg));

    always_comb
    begin
        case (cmd.rd_sel)
            dcf_pkg::RD_I: raddr = i_reg[IW-1:0];
            dcf_pkg::RD_K: raddr = k_reg[IW-1:0];
            dcf_pkg::RD_J: raddr = j_reg;
            default:       raddr = i_reg[IW-1:0];
        endcase
    end

    assign store_we   = cmd.load_pt && (load_cnt_reg != CW'(MAX_POINTS));
    assign link_we    = cmd.init_wr || (cmd.k_cmp && hit) || cmd.sweep_end;
    assign link_waddr = cmd.sweep_end ? j_reg : k_reg[IW-1:0];
    assign link_wdata = cmd.init_wr ? k_reg[IW-1:0] : jlink_reg;

    for (genvar a = 0; a < 3; a++)
    begin : g_store
        dcf_ram #(
            .WIDTH(CB),
            .DEPTH(MAX_POINTS)
        ) u_coord (
            .clk  (clk),
            .we   (store_we),
            .waddr(load_cnt_reg[IW-1:0]),
            .wdata(CB'(pos[a])),
            .raddr(raddr),
            .rdata(coord_rd[a])
        );
    end

    dcf_ram #(
        .WIDTH(IW),
        .DEPTH(MAX_POINTS)
    ) u_link (
        .clk  (clk),
        .we   (link_we),
        .waddr(link_waddr),
        .wdata(link_wdata),
        .raddr(raddr),
        .rdata(link_rd)
    );

    dcf_div #(
        .NUM_W(SW),
        .DEN_W(CW),
        .LANES(3)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .num  (sum_reg),
        .den  (best_size_reg),
        .busy (div_busy),
        .quo  (quo)
    );

    always_comb
    begin
        stat.k_done     = k_reg == n_reg;
        stat.outer_done = i_reg == n_reg;
        stat.link_self  = link_rd == i_reg[IW-1:0];
        stat.hit        = hit;
        stat.walk_more  = (jlink_reg != i_reg[IW-1:0]) && (steps_inc < n_wide);
        stat.best_empty = best_size_reg == '0;
        stat.sum_more   = (link_rd != best_start_reg) && (steps_inc < n_wide);
        stat.div_busy   = div_busy;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg     <= '0;
            bead_reg       <= '0;
            load_cnt_reg   <= '0;
            n_reg          <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            steps_reg      <= '0;
            size_reg       <= '0;
            clusters_reg   <= '0;
            best_size_reg  <= '0;
            best_start_reg <= '0;
            j_reg          <= '0;
            jlink_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dcf_pkg::REG_CUTOFF: cutoff_reg <= cfg_data[dcf_pkg::CUT_W-1:0];
                    dcf_pkg::REG_BEAD:   bead_reg   <= cfg_data[dcf_pkg::CNT_W-1:0];
                    default:             bead_reg   <= bead_reg;
                endcase
            end

            if (store_we)
            begin
                load_cnt_reg <= load_cnt_reg + CW'(1);
            end

            if (cmd.run_start)
            begin
                n_reg          <= n_sat;
                i_reg          <= '0;
                k_reg          <= '0;
                size_reg       <= '0;
                clusters_reg   <= '0;
                best_size_reg  <= '0;
                best_start_reg <= '0;
            end
            else if (cmd.init_wr)
            begin
                k_reg <= k_reg + CW'(1);
            end
            else if (cmd.outer_skip)
            begin
                i_reg <= i_reg + CW'(1);
            end
            else if (cmd.outer_open)
            begin
                clusters_reg <= clusters_reg + CW'(1);
                size_reg     <= CW'(1);
                j_reg        <= i_reg[IW-1:0];
                jlink_reg    <= i_reg[IW-1:0];
                steps_reg    <= '0;
                k_reg        <= i_reg + CW'(1);
            end
            else if (cmd.k_cmp)
            begin
                if (hit)
                begin
                    jlink_reg <= k_reg[IW-1:0];
                    size_reg  <= size_reg + CW'(1);
                end
                k_reg <= k_reg + CW'(1);
            end
            else if (cmd.sweep_end)
            begin
                j_reg     <= jlink_reg;
                steps_reg <= steps_reg + CW'(1);
            end
            else if (cmd.j_latch)
            begin
                jlink_reg <= link_rd;
                k_reg     <= i_reg + CW'(1);
            end
            else if (cmd.cluster_end)
            begin
                if (size_reg > best_size_reg)
                begin
                    best_size_reg  <= size_reg;
                    best_start_reg <= i_reg[IW-1:0];
                end
                i_reg <= i_reg + CW'(1);
            end
            else if (cmd.sum_start)
            begin
                j_reg     <= best_start_reg;
                steps_reg <= '0;
            end
            else if (cmd.sum_acc)
            begin
                j_reg     <= link_rd;
                steps_reg <= steps_reg + CW'(1);
            end

            if (cmd.out_load)
            begin
                load_cnt_reg  <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff_reg[a] <= DFW'(jc_reg[a]) - DFW'($signed(coord_rd[a]));
            sq_reg[a]   <= SQW'(diff_reg[a] * diff_reg[a]);
        end
        dsum_reg <= DSW'(sq_reg[0]) + DSW'(sq_reg[1]) + DSW'(sq_reg[2]);
        free_reg <= link_rd == k_reg[IW-1:0];

        if (cmd.outer_open || cmd.j_latch)
        begin
            for (int a = 0; a < 3; a++)
            begin
                jc_reg[a] <= $signed(coord_rd[a]);
            end
        end

        if (cmd.sum_start)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else if (cmd.sum_acc)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= sum_reg[a] + SW'($signed(coord_rd[a]));
            end
        end

        if (cmd.out_load)
        begin
            cnt_out_reg   <= dcf_pkg::CNT_W'(clusters_reg);
            size_out_reg  <= dcf_pkg::CNT_W'(best_size_reg);
            start_out_reg <= dcf_pkg::START_W'(best_start_reg);
            for (int a = 0; a < 3; a++)
            begin
                centre_reg[a] <= (best_size_reg == '0) ? '0 : dcf_pkg::IN_W'(quo[a]);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign cluster_count = cnt_out_reg;
    assign largest_size  = size_out_reg;
    assign largest_start = start_out_reg;
    assign centre_x      = centre_reg[0];
    assign centre_y      = centre_reg[1];
    assign centre_z      = centre_reg[2];

    a_clusters_bound: assert property (@(posedge clk) disable iff (!rst_n)
        clusters_reg <= n_reg)
        else $error("cluster count exceeds point count");

    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        best_size_reg <= n_reg)
        else $error("largest cluster exceeds point count");

    a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (load_cnt_reg == '0) && out_valid_reg)
        else $error("result load did not clear load counter");

endmodule

// File: hdl/dcf_ctrl.sv
module dcf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_stall,
    output dcf_pkg::dp_cmd_t  cmd,
    input  dcf_pkg::dp_stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_OUTER_RD,
        S_OUTER_CHK,
        S_K_RD,
        S_K_DIFF,
        S_K_SQ,
        S_K_SUM,
        S_K_CMP,
        S_SWEEP_END,
        S_J_RD,
        S_J_LATCH,
        S_CLUSTER_END,
        S_SUM_START,
        S_SUM_RD,
        S_SUM_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = state_reg != S_IDLE;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = dcf_pkg::RD_I;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == dcf_pkg::CMD_RUN)
                    begin
                        cmd.run_start = 1'b1;
                        state_next    = S_INIT;
                    end
                    else
                    begin
                        cmd.load_pt = 1'b1;
                    end
                end
            end
            S_INIT:
            begin
                if (stat.k_done)
                begin
                    state_next = S_OUTER_RD;
                end
                else
                begin
                    cmd.init_wr = 1'b1;
                end
            end
            S_OUTER_RD:
            begin
                state_next = stat.outer_done ? S_SUM_START : S_OUTER_CHK;
            end
            S_OUTER_CHK:
            begin
                if (stat.link_self)
                begin
                    cmd.outer_open = 1'b1;
                    state_next     = S_K_RD;
                end
                else
                begin
                    cmd.outer_skip = 1'b1;
                    state_next     = S_OUTER_RD;
                end
            end
            S_K_RD:
            begin
                cmd.rd_sel = dcf_pkg::RD_K;
                state_next = stat.k_done ? S_SWEEP_END : S_K_DIFF;
            end
            S_K_DIFF:
            begin
                cmd.rd_sel = dcf_pkg::RD_K;
                state_next = S_K_SQ;
            end
            S_K_SQ:
            begin
                cmd.rd_sel = dcf_pkg::RD_K;
                state_next = S_K_SUM;
            end
            S_K_SUM:
            begin
                cmd.rd_sel = dcf_pkg::RD_K;
                state_next = S_K_CMP;
            end
            S_K_CMP:
            begin
                cmd.rd_sel = dcf_pkg::RD_K;
                cmd.k_cmp  = 1'b1;
                state_next = S_K_RD;
            end
            S_SWEEP_END:
            begin
                cmd.sweep_end = 1'b1;
                state_next    = stat.walk_more ? S_J_RD : S_CLUSTER_END;
            end
            S_J_RD:
            begin
                cmd.rd_sel = dcf_pkg::RD_J;
                state_next = S_J_LATCH;
            end
            S_J_LATCH:
            begin
                cmd.rd_sel  = dcf_pkg::RD_J;
                cmd.j_latch = 1'b1;
                state_next  = S_K_RD;
            end
            S_CLUSTER_END:
            begin
                cmd.cluster_end = 1'b1;
                state_next      = S_OUTER_RD;
            end
            S_SUM_START:
            begin
                if (stat.best_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.sum_start = 1'b1;
                    state_next    = S_SUM_RD;
                end
            end
            S_SUM_RD:
            begin
                cmd.rd_sel = dcf_pkg::RD_J;
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                cmd.rd_sel  = dcf_pkg::RD_J;
                cmd.sum_acc = 1'b1;
                state_next  = stat.sum_more ? S_SUM_RD : S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_cmd == dcf_pkg::CMD_RUN) |=> in_stall)
        else $error("run beat accepted but block not busy");

endmodule

// File: hdl/distance_cluster_finder.sv
// Point clusterer. A load beat (cmd 0) stores one point and the block takes the next
// beat in the following cycle; loads past MAX_POINTS are dropped. A run beat (cmd 1)
// groups the first bead_count points (capped at MAX_POINTS) by single linkage and
// returns one summary beat. A run seeds the ring links of all n points, scans each
// point, checks candidate distances for each ring member visited (one shared
// subtract/square/sum/compare datapath reading one store port), walks each ring member,
// sums the coordinates of each member of the largest cluster, and ends with the
// bit-serial mean divide. Input is stalled for the whole run.
// The load counter returns to zero once the result is issued.
module distance_cluster_finder #(
    parameter int MAX_POINTS = dcf_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dcf_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcf_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic signed [dcf_pkg::IN_W-1:0]   pos_x,
    input  logic signed [dcf_pkg::IN_W-1:0]   pos_y,
    input  logic signed [dcf_pkg::IN_W-1:0]   pos_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dcf_pkg::CNT_W-1:0]         cluster_count,
    output logic [dcf_pkg::CNT_W-1:0]         largest_size,
    output logic [dcf_pkg::START_W-1:0]       largest_start,
    output logic signed [dcf_pkg::IN_W-1:0]   centre_x,
    output logic signed [dcf_pkg::IN_W-1:0]   centre_y,
    output logic signed [dcf_pkg::IN_W-1:0]   centre_z
);

    dcf_pkg::dp_cmd_t  dp_cmd;
    dcf_pkg::dp_stat_t dp_stat;

    dcf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_cmd  (cmd),
        .in_stall(in_stall),
        .cmd     (dp_cmd),
        .stat    (dp_stat)
    );

    dcf_datapath #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .cluster_count(cluster_count),
        .largest_size (largest_size),
        .largest_start(largest_start),
        .centre_x     (centre_x),
        .centre_y     (centre_y),
        .centre_z     (centre_z)
    );

endmodule
